// ===== design/sla_pkg.sv =====
// shared constants and types for the semi-lagrangian bilinear advection core
// no dependencies
package sla_pkg;

    localparam int GRID_N_DEF = 256;
    localparam int COORD_W    = 9;
    localparam int DENS_W     = 16;
    localparam int VEL_W      = 16;
    localparam int SCALE_W    = 16;
    localparam logic [15:0] SCALE_RST = 16'd655;
    localparam int FRAC_W     = 12;
    localparam int QUEUE_DEPTH = 4;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_ADVECT = 1'b1;

    localparam logic [0:0] REG_SCALE = 1'b0;

    // one classified item handed from front to back
    typedef struct packed {
        logic                     is_write;
        logic [COORD_W-1:0]       cx;
        logic [COORD_W-1:0]       cy;
        logic signed [DENS_W-1:0] dens;
        logic signed [VEL_W-1:0]  vu;
        logic signed [VEL_W-1:0]  vv;
    } item_t;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_TRACE = 6'b000100,
        ST_READ  = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_MIX   = 6'b100000
    } back_state_t;

endpackage

// ===== design/semi_lagrangian_advect_bilinear_core.sv =====
// Semi-lagrangian bilinear advection core, built from sla_front, sla_back and sla_pkg.
// A write item is popped and written in the back end in the same cycle; an advect item
// steps through pop, trace, four reads of the single ported store, a wait for the read
// latency, two multiply stages and round. busy rises while the input queue is full. After
// reset the store is cleared cell by cell while items queue up.
// The result strobe density_valid lasts one cycle and cannot be held off.
module semi_lagrangian_advect_bilinear_core #(
    parameter int GRID_N = sla_pkg::GRID_N_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [8:0]  cell_x,
    input  logic [8:0]  cell_y,
    input  logic signed [15:0] density_in,
    input  logic signed [15:0] vel_u,
    input  logic signed [15:0] vel_v,
    output logic        density_valid,
    output logic signed [15:0] density_out,
    output logic [8:0]  out_x,
    output logic [8:0]  out_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]    scale_reg;
    logic           full, empty, pop;
    sla_pkg::item_t item, head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sla_pkg::REG_SCALE) ? {16'd0, scale_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= sla_pkg::SCALE_RST;
        end
        else if (psel && penable && pwrite && paddr[2] == sla_pkg::REG_SCALE)
        begin
            scale_reg <= pwdata[15:0];
        end
    end

    assign busy = full;
    assign item = '{is_write: (action == sla_pkg::ACT_WRITE), cx: cell_x, cy: cell_y,
                    dens: density_in, vu: vel_u, vv: vel_v};

    sla_front u_front (
        .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_item(item),
        .full(full), .pop(pop), .empty(empty), .head(head)
    );

    sla_back #(.GRID_N(GRID_N)) u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .head(head), .pop(pop),
        .scale(scale_reg), .res_valid(density_valid),
        .res_dens(density_out), .res_x(out_x), .res_y(out_y)
    );

endmodule

// ===== design/sla_ram.sv =====
// generic single port ram with registered read
// no dependencies
module sla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sla_front.sv =====
// front end: accepts items into a short queue
// depends on sla_pkg
module sla_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sla_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output sla_pkg::item_t head
);

    localparam int AW = $clog2(sla_pkg::QUEUE_DEPTH);

    sla_pkg::item_t   q_reg [sla_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    rp_reg;
    logic [AW:0]      cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(sla_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ===== design/sla_back.sv =====
// back end: clears the store, performs writes, traces and interpolates advects
// depends on sla_pkg and sla_ram
module sla_back #(
    parameter int GRID_N = sla_pkg::GRID_N_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              empty,
    input  sla_pkg::item_t                    head,
    output logic                              pop,
    input  logic [sla_pkg::SCALE_W-1:0]       scale,
    output logic                              res_valid,
    output logic signed [sla_pkg::DENS_W-1:0] res_dens,
    output logic [sla_pkg::COORD_W-1:0]       res_x,
    output logic [sla_pkg::COORD_W-1:0]       res_y
);

    localparam int SIDE  = GRID_N + 2;
    localparam int CELLS = SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(GRID_N + 2);
    // position width: cell*2^20 minus a 32 bit product, signed
    localparam int PW    = sla_pkg::COORD_W + 25;
    // clamped position in q.12
    localparam int QW    = IW + 12;
    localparam logic signed [PW-1:0] LO = PW'(1) <<< 19;
    localparam logic signed [PW-1:0] HI = (PW'(GRID_N) <<< 20) + LO;

    sla_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]  clr_reg;
    sla_pkg::item_t it_reg;
    logic [IW-1:0]  ix_reg, iy_reg;
    logic [11:0]    fx_reg, fy_reg;
    logic [1:0]     k_reg;
    logic signed [15:0] d_reg [4];
    logic signed [31:0] pu_reg, pv_reg;
    logic           tr_reg;

    logic           we;
    logic [AW-1:0]  addr;
    logic [15:0]    wdata, rdata;

    sla_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    function automatic logic [AW-1:0] cell_addr(input logic [IW:0] x, input logic [IW:0] y);
        logic [AW+IW:0] t;
        t = (AW+IW+1)'(y) * (AW+IW+1)'(SIDE) + (AW+IW+1)'(x);
        return t[AW-1:0];
    endfunction

    logic signed [PW-1:0] pos_x, pos_y;
    logic [QW-1:0]        qx, qy;
    logic                 wr_ok;

    always_comb
    begin
        pos_x = $signed(PW'(it_reg.cx) <<< 20) - PW'(pu_reg);
        pos_y = $signed(PW'(it_reg.cy) <<< 20) - PW'(pv_reg);
        if (pos_x < LO) pos_x = LO;
        if (pos_x > HI) pos_x = HI;
        if (pos_y < LO) pos_y = LO;
        if (pos_y > HI) pos_y = HI;
        qx = pos_x[QW+7:8];
        qy = pos_y[QW+7:8];
    end

    assign wr_ok = (head.cx <= 9'(GRID_N + 1)) && (head.cy <= 9'(GRID_N + 1));

    // interpolation datapath, registered between the multiplies
    logic signed [30:0] w1_reg, w2_reg;
    logic signed [47:0] w_reg;
    logic [1:0]         mix_reg;

    always_comb
    begin
        state_next = state_reg;
        pop   = 1'b0;
        we    = 1'b0;
        addr  = cell_addr((IW+1)'(ix_reg) + (IW+1)'(k_reg[0]),
                          (IW+1)'(iy_reg) + (IW+1)'(k_reg[1]));
        wdata = head.dens;
        case (state_reg)
            sla_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                addr  = clr_reg;
                wdata = '0;
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = sla_pkg::ST_IDLE;
                end
            end
            sla_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.is_write)
                    begin
                        we   = wr_ok;
                        addr = cell_addr((IW+1)'(head.cx), (IW+1)'(head.cy));
                    end
                    else
                    begin
                        state_next = sla_pkg::ST_TRACE;
                    end
                end
            end
            sla_pkg::ST_TRACE: state_next = sla_pkg::ST_READ;
            sla_pkg::ST_READ:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = sla_pkg::ST_WAIT;
                end
            end
            sla_pkg::ST_WAIT: state_next = sla_pkg::ST_MIX;
            sla_pkg::ST_MIX:
            begin
                if (mix_reg == 2'd2)
                begin
                    state_next = sla_pkg::ST_IDLE;
                end
            end
            default: state_next = sla_pkg::ST_IDLE;
        endcase
    end

    logic signed [47:0] rnd;
    assign rnd = w_reg + 48'sd8388608;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sla_pkg::ST_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            mix_reg   <= '0;
            tr_reg    <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid <= 1'b0;
            // read data follows the address in the next cycle
            tr_reg    <= (state_reg == sla_pkg::ST_READ);
            if (state_reg == sla_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == sla_pkg::ST_READ)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == sla_pkg::ST_MIX)
            begin
                mix_reg <= (mix_reg == 2'd2) ? 2'd0 : mix_reg + 1'b1;
                if (mix_reg == 2'd2)
                begin
                    res_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sla_pkg::ST_IDLE)
        begin
            it_reg <= head;
            pu_reg <= head.vu * $signed({1'b0, scale});
            pv_reg <= head.vv * $signed({1'b0, scale});
        end
        if (state_reg == sla_pkg::ST_TRACE)
        begin
            ix_reg <= qx[QW-1:12];
            iy_reg <= qy[QW-1:12];
            fx_reg <= qx[11:0];
            fy_reg <= qy[11:0];
        end
        if (tr_reg)
        begin
            d_reg[k_reg - 2'd1] <= rdata;
        end
        if (state_reg == sla_pkg::ST_MIX)
        begin
            case (mix_reg)
                2'd0:
                begin
                    w1_reg <= d_reg[0] * $signed({1'b0, 13'd4096 - 13'(fx_reg)})
                            + d_reg[1] * $signed({1'b0, fx_reg});
                    w2_reg <= d_reg[2] * $signed({1'b0, 13'd4096 - 13'(fx_reg)})
                            + d_reg[3] * $signed({1'b0, fx_reg});
                end
                2'd1:
                begin
                    w_reg <= w1_reg * $signed({1'b0, 13'd4096 - 13'(fy_reg)})
                           + w2_reg * $signed({1'b0, fy_reg});
                end
                default:
                begin
                    if (rnd >>> 24 > 48'sd32767)
                    begin
                        res_dens <= 16'sd32767;
                    end
                    else if (rnd >>> 24 < -48'sd32768)
                    begin
                        res_dens <= -16'sd32768;
                    end
                    else
                    begin
                        res_dens <= rnd[39:24];
                    end
                    res_x <= it_reg.cx;
                    res_y <= it_reg.cy;
                end
            endcase
        end
    end

endmodule
